>>> sv/kots_pkg.sv
// ----------------------------------------------------------------------------
// kots_pkg
// Shared types and constants for the keyed ordered take store.
// ----------------------------------------------------------------------------
package kots_pkg;

    localparam int KOTS_CAPACITY = 32;
    localparam int KEY_W         = 16;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } t_state;

endpackage

>>> sv/kots_ram.sv
// ----------------------------------------------------------------------------
// kots_ram
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kots_ram #(
    parameter int Capacity = kots_pkg::KOTS_CAPACITY,
    parameter int IdxW     = 5
) (
    input  logic              i_clk,
    input  kots_pkg::t_ram_ctl i_ctl,
    input  logic [IdxW-1:0]   i_waddr,
    input  kots_pkg::t_entry  i_wdata,
    input  logic [IdxW-1:0]   i_raddr,
    output kots_pkg::t_entry  o_rdata
);
    import kots_pkg::*;

    t_entry r_mem [Capacity];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/kots_engine.sv
// ----------------------------------------------------------------------------
// kots_engine
// Sequencer: appends on add, and on take scans the memory oldest first,
// captures the first match and moves every later entry down one slot in the
// same pass. Holds the occupancy count and the output register.
// ----------------------------------------------------------------------------
module kots_engine #(
    parameter int Capacity = kots_pkg::KOTS_CAPACITY,
    parameter int IdxW     = 5,
    parameter int CntW     = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [kots_pkg::KEY_W-1:0]      i_key,
    input  logic [kots_pkg::DATA_W-1:0]     i_data_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [kots_pkg::STATUS_W-1:0]   o_status,
    output logic [kots_pkg::DATA_W-1:0]     o_data_out,
    output kots_pkg::t_ram_ctl              o_ram_ctl,
    output logic [IdxW-1:0]                 o_ram_waddr,
    output kots_pkg::t_entry                o_ram_wdata,
    output logic [IdxW-1:0]                 o_ram_raddr,
    input  kots_pkg::t_entry                i_ram_rdata
);
    import kots_pkg::*;

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_occ, n_occ;
    logic [CntW-1:0]     r_n, n_n;
    logic [CntW-1:0]     r_issue, n_issue;
    logic                r_chk_valid, n_chk_valid;
    logic [IdxW-1:0]     r_chk_idx, n_chk_idx;
    logic                r_found, n_found;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_data, n_out_data;

    logic in_accept;
    logic full;
    logic issue_ok;
    logic match;
    logic last;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign full      = (r_occ == CntW'(Capacity));
    assign issue_ok  = (r_issue < r_n);
    assign match     = r_chk_valid && (i_ram_rdata.key == r_key);
    assign last      = r_chk_valid && (CntW'(r_chk_idx) == (r_n - CntW'(1)));

    always_comb begin
        o_ram_ctl.wr_en = (in_accept && (i_action == ACT_ADD) && !full)
                          || ((r_state == ST_SCAN) && r_chk_valid && r_found);
        o_ram_ctl.rd_en = (r_state == ST_SCAN) && issue_ok;
        if (r_state == ST_IDLE) begin
            o_ram_waddr        = r_occ[IdxW-1:0];
            o_ram_wdata.key    = i_key;
            o_ram_wdata.handle = i_data_in;
        end else begin
            o_ram_waddr = r_chk_idx - IdxW'(1);
            o_ram_wdata = i_ram_rdata;
        end
        o_ram_raddr = r_issue[IdxW-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_n          = r_n;
        n_issue      = r_issue;
        n_chk_valid  = r_chk_valid;
        n_chk_idx    = r_chk_idx;
        n_found      = r_found;
        n_key        = r_key;
        n_status     = r_status;
        n_data       = r_data;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_RESULT;
                    n_data  = '0;
                    if (i_action == ACT_ADD) begin
                        if (full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_status = STATUS_OK;
                            n_occ    = r_occ + CntW'(1);
                        end
                    end else begin
                        n_key       = i_key;
                        n_n         = r_occ;
                        n_issue     = '0;
                        n_chk_valid = 1'b0;
                        n_found     = 1'b0;
                        n_status    = STATUS_NOT_FOUND;
                        if (r_occ != '0) begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                n_chk_valid = issue_ok;
                n_chk_idx   = r_issue[IdxW-1:0];
                if (issue_ok) begin
                    n_issue = r_issue + CntW'(1);
                end
                if (match && !r_found) begin
                    n_found = 1'b1;
                    n_data  = i_ram_rdata.handle;
                end
                if (last) begin
                    n_state = ST_RESULT;
                    if (r_found || match) begin
                        n_status = STATUS_OK;
                        n_occ    = r_occ - CntW'(1);
                    end else begin
                        n_status = STATUS_NOT_FOUND;
                        n_data   = '0;
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = r_data;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_issue      <= n_issue;
        r_chk_idx    <= n_chk_idx;
        r_found      <= n_found;
        r_key        <= n_key;
        r_status     <= n_status;
        r_data       <= n_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_out  = r_out_data;

endmodule

>>> sv/keyed_ordered_take_store.sv
// ----------------------------------------------------------------------------
// keyed_ordered_take_store
// Bounded store of key and handle entries in arrival order, with add at the
// tail and take of the oldest entry that matches a key.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                  | Fields
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_action, i_key, i_data_in
//  out     | output    | o_out_valid / i_out_stall  | o_status, o_data_out
//
// An add beat, or a take beat on an empty store, goes from acceptance to the
// RESULT state and from there into the output register. Any other take beat
// first passes through the SCAN state, in which the entry memory is swept once
// through its single read port, oldest slot first.
// One beat is worked on at a time. Synchronous reset empties the store; the
// memory itself is not cleared. The next input beat can be accepted while a
// result still waits in the output register.
// ----------------------------------------------------------------------------
module keyed_ordered_take_store #(
    parameter int Capacity = kots_pkg::KOTS_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [kots_pkg::KEY_W-1:0]    i_key,
    input  logic [kots_pkg::DATA_W-1:0]   i_data_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kots_pkg::STATUS_W-1:0] o_status,
    output logic [kots_pkg::DATA_W-1:0]   o_data_out
);
    import kots_pkg::*;

    localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
    localparam int CntW = $clog2(Capacity + 1);

    t_ram_ctl        ram_ctl;
    logic [IdxW-1:0] ram_waddr;
    logic [IdxW-1:0] ram_raddr;
    t_entry          ram_wdata;
    t_entry          ram_rdata;

    kots_ram #(
        .Capacity (Capacity),
        .IdxW     (IdxW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kots_engine #(
        .Capacity (Capacity),
        .IdxW     (IdxW),
        .CntW     (CntW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_ram_ctl   (ram_ctl),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

>>> sv/kots_checker.sv
// ----------------------------------------------------------------------------
// kots_port_checker
// Port-level checks for the keyed ordered take store, bound to the top level.
// ----------------------------------------------------------------------------
module kots_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [kots_pkg::STATUS_W-1:0] o_status,
    input logic [kots_pkg::DATA_W-1:0]   o_data_out
);
    import kots_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_data_out))
        else $error("Stalled output beat changed or was dropped.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK) || (o_status == STATUS_NOT_FOUND)
                        || (o_status == STATUS_FULL))
        else $error("Output status carries an undefined code.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STATUS_OK) |-> (o_data_out == '0))
        else $error("Failed beat returned a non-zero handle.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input accepted a second beat while the first was in work.");

endmodule

bind keyed_ordered_take_store kots_port_checker u_kots_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_data_out  (o_data_out)
);
